// ===== sv/crc8_checked_word_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-8 word frame receiver
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CRC8_CHECKED_WORD_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_CHECKED_WORD_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define CRC8WFR_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CRC8WFR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define CRC8WFR_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg)
`define CRC8WFR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)

`endif

`endif

// ===== sv/crc8wfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-8 word frame receiver package
// Word types shared by the receiver and its word store, plus the CRC
// constants and the per-byte CRC-8 step used by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8wfr_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 3;
    localparam int BAD_W     = 3;
    localparam int IDX_W     = 4;
    localparam int OUT_WORDS = 6;

    // CRC-8: poly 0x31, init 0xFF, no reflection, no final xor
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

    // Lead word value that flags data ready
    localparam logic [WORD_W-1:0] READY_WORD = 16'h0001;

    // Frame length after reset
    localparam logic [LEN_W-1:0] WORDS_RESET = 3'd6;

    // Position of a byte inside its word
    typedef enum logic [2:0] {
        PH_MSB = 3'b001,
        PH_LSB = 3'b010,
        PH_CRC = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
        logic [VALUE_W-1:0] third_value;
        logic [WORD_W-1:0]  lead_word;
        logic               ready_flag;
        logic               crc_status;
        logic [BAD_W-1:0]   bad_word_index;
    } out_word_t;

    // Store write control: clear all entries, then write one byte of one entry
    typedef struct packed {
        logic              clear;
        logic              wr_hi;
        logic              wr_lo;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } store_ctrl_t;

    typedef logic [OUT_WORDS-1:0][WORD_W-1:0] word_set_t;

    // Feed one byte through the CRC-8, MSB first
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int b = 0; b < BYTE_W; b++) begin
            if ((c & CRC_MSB) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/crc8wfr_word_store.sv =====
// ----------------------------------------------------------------------------
// Word store
// Holds the data half of each received word of the current frame; entries
// clear together at frame start and after a frame completes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8wfr_word_store #(
    parameter int MAX_WORDS = 6
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire crc8wfr_pkg::store_ctrl_t ctrl,
    output crc8wfr_pkg::word_set_t        words
);

    logic [crc8wfr_pkg::WORD_W-1:0] store_reg  [MAX_WORDS];
    logic [crc8wfr_pkg::WORD_W-1:0] store_next [MAX_WORDS];

    // Clear, then write the addressed byte
    always_comb
    begin
        for (int i = 0; i < MAX_WORDS; i++) begin
            store_next[i] = ctrl.clear ? '0 : store_reg[i];
            if (ctrl.idx == crc8wfr_pkg::IDX_W'(i))
            begin
                if (ctrl.wr_hi)
                begin
                    store_next[i] = {ctrl.data, {crc8wfr_pkg::BYTE_W{1'b0}}};
                end
                if (ctrl.wr_lo)
                begin
                    store_next[i] = store_next[i] |
                                    {{crc8wfr_pkg::BYTE_W{1'b0}}, ctrl.data};
                end
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WORDS; i++) begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_WORDS; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    // Present the output words; words past the store read as zero
    for (genvar g = 0; g < crc8wfr_pkg::OUT_WORDS; g++) begin : g_word
        if (g < MAX_WORDS) begin : g_held
            assign words[g] = store_reg[g];
        end
        else begin : g_none
            assign words[g] = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/crc8_checked_word_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// CRC-8 checked word frame receiver: one byte per cycle, CRC checked per word
// Result valid in the cycle after the last word's CRC byte is accepted.
// Throughput one byte per cycle; in_ready drops only for a CRC byte while a result waits.
// Async reset: frame length 6, empty frame, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc8_checked_word_frame_receiver_assert.svh"

module crc8_checked_word_frame_receiver #(
    parameter int MAX_WORDS = 6
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire crc8wfr_pkg::in_word_t               in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output crc8wfr_pkg::out_word_t                   out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [crc8wfr_pkg::LEN_W-1:0]       cfg_data
);

    localparam int CW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LENW = (CW + 1 > crc8wfr_pkg::LEN_W) ? CW + 1 : crc8wfr_pkg::LEN_W;

    logic [crc8wfr_pkg::LEN_W-1:0]  wpf_reg;
    crc8wfr_pkg::phase_t            phase_reg, phase_next, phase_eff;
    logic [CW-1:0]                  count_reg, count_next, count_eff;
    logic [crc8wfr_pkg::BYTE_W-1:0] crc_reg, crc_next;
    logic                           err_reg, err_next, err_eff, err_hit;
    logic [CW-1:0]                  bad_reg, bad_next, bad_eff, bad_hit;
    logic [crc8wfr_pkg::IDX_W-1:0]  bad_ext;
    logic [LENW-1:0]                frame_len, count_plus;
    logic                           in_fire, result_fire;
    logic                           out_valid_reg;
    crc8wfr_pkg::out_word_t         out_data_reg, result;
    crc8wfr_pkg::store_ctrl_t       store_ctrl;
    crc8wfr_pkg::word_set_t         words;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready || (phase_reg != crc8wfr_pkg::PH_CRC);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Clamp the configured length to 1..MAX_WORDS
    always_comb
    begin
        frame_len = LENW'(wpf_reg);
        if (wpf_reg == '0)
        begin
            frame_len = LENW'(1);
        end
        else if (LENW'(wpf_reg) > LENW'(MAX_WORDS))
        begin
            frame_len = LENW'(MAX_WORDS);
        end
    end

    // Frame start drops the partial frame
    assign phase_eff  = in_data.frame_start ? crc8wfr_pkg::PH_MSB : phase_reg;
    assign count_eff  = in_data.frame_start ? '0 : count_reg;
    assign err_eff    = in_data.frame_start ? 1'b0 : err_reg;
    assign bad_eff    = in_data.frame_start ? '0 : bad_reg;
    assign count_plus = LENW'(count_reg) + LENW'(1);

    // Record the first bad word
    assign err_hit = err_eff || (crc_reg != in_data.rx_byte);
    assign bad_hit = err_eff ? bad_eff : count_eff;
    assign bad_ext = crc8wfr_pkg::IDX_W'(bad_hit);

    // Advance the byte phase, CRC and word count
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        crc_next         = crc_reg;
        err_next         = err_reg;
        bad_next         = bad_reg;
        result_fire      = 1'b0;
        store_ctrl.clear = 1'b0;
        store_ctrl.wr_hi = 1'b0;
        store_ctrl.wr_lo = 1'b0;
        store_ctrl.idx   = crc8wfr_pkg::IDX_W'(count_eff);
        store_ctrl.data  = in_data.rx_byte;
        if (in_fire)
        begin
            store_ctrl.clear = in_data.frame_start;
            count_next       = count_eff;
            err_next         = err_eff;
            bad_next         = bad_eff;
            case (phase_eff)
                crc8wfr_pkg::PH_MSB:
                begin
                    crc_next         = crc8wfr_pkg::crc8_feed(crc8wfr_pkg::CRC_INIT,
                                                              in_data.rx_byte);
                    store_ctrl.wr_hi = 1'b1;
                    phase_next       = crc8wfr_pkg::PH_LSB;
                end
                crc8wfr_pkg::PH_LSB:
                begin
                    crc_next         = crc8wfr_pkg::crc8_feed(crc_reg, in_data.rx_byte);
                    store_ctrl.wr_lo = 1'b1;
                    phase_next       = crc8wfr_pkg::PH_CRC;
                end
                crc8wfr_pkg::PH_CRC:
                begin
                    crc_next   = crc8wfr_pkg::CRC_INIT;
                    phase_next = crc8wfr_pkg::PH_MSB;
                    if (count_plus < frame_len)
                    begin
                        count_next = count_reg + CW'(1);
                        err_next   = err_hit;
                        bad_next   = bad_hit;
                    end
                    else
                    begin
                        result_fire      = 1'b1;
                        store_ctrl.clear = 1'b1;
                        count_next       = '0;
                        err_next         = 1'b0;
                        bad_next         = '0;
                    end
                end
                default:
                begin
                    crc_next   = crc8wfr_pkg::CRC_INIT;
                    phase_next = crc8wfr_pkg::PH_MSB;
                end
            endcase
        end
    end

    // Build the frame result from the stored words and the CRC error state
    always_comb
    begin
        result.first_value    = {words[0], words[1]};
        result.second_value   = {words[2], words[3]};
        result.third_value    = {words[4], words[5]};
        result.lead_word      = words[0];
        result.ready_flag     = (words[0] == crc8wfr_pkg::READY_WORD);
        result.crc_status     = err_hit;
        result.bad_word_index = err_hit ? bad_ext[crc8wfr_pkg::BAD_W-1:0] : '0;
    end

    crc8wfr_word_store #(
        .MAX_WORDS (MAX_WORDS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (store_ctrl),
        .words (words)
    );

    // Hold frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpf_reg   <= crc8wfr_pkg::WORDS_RESET;
            phase_reg <= crc8wfr_pkg::PH_MSB;
            count_reg <= '0;
            crc_reg   <= crc8wfr_pkg::CRC_INIT;
            err_reg   <= 1'b0;
            bad_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wpf_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
            err_reg   <= err_next;
            bad_reg   <= bad_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_fire)
        begin
            out_data_reg <= result;
        end
    end

    `CRC8WFR_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, result_fire, !out_valid_reg || out_ready, "result overwrites a pending word")
    `CRC8WFR_ASSERT_IMPLY(a_rise_from_crc, clk, rst_n, $rose(out_valid_reg), $past(in_fire && phase_reg == crc8wfr_pkg::PH_CRC), "result without a CRC byte")
    `CRC8WFR_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, LENW'(count_reg) < LENW'(MAX_WORDS), "word count past store depth")
    `CRC8WFR_ASSERT_IMPLY(a_bad_index_clean, clk, rst_n, out_valid_reg && !out_data_reg.crc_status, out_data_reg.bad_word_index == '0, "bad index set without CRC error")
    `CRC8WFR_ASSERT_NEXT(a_crc_rearm, clk, rst_n, in_fire && phase_eff == crc8wfr_pkg::PH_CRC, crc_reg == crc8wfr_pkg::CRC_INIT, "CRC not re-armed after CRC byte")

endmodule

`default_nettype wire
